/* rtl/plids_pkg.sv */
// Shared types, codes and sizes for the positional list block.
package plids_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CMD_W     = 3;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 3;
    localparam int FIDX_W    = 6;
    localparam int QDEPTH    = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd5;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_BADPOS   = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_BADCMD   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_INSERT,
        OP_DELETE,
        OP_SEARCH,
        OP_DUMP,
        OP_BADCMD
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_WR,
        ST_PUT,
        ST_DN_RD,
        ST_DN_WR,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DUMP_RD,
        ST_DUMP_OUT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] operand_value;
    } cmd_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [FIDX_W-1:0]       found_index;
        logic signed [VAL_W-1:0] entry_value;
        logic [POS_W-1:0]        entry_count;
        logic                    last;
    } res_word_t;

    typedef struct packed {
        op_t                     op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } q_entry_t;

endpackage

/* rtl/positional_list_insert_delete_search.sv */
// Top level of the positional list: intake, command queue and execution unit.
// Each command word gives one result word, except a dump of a non-empty list, which gives one
// result per entry in order with last set on the final one. Clear, append, bad commands and
// rejected commands go straight to the response. Search reads and compares entries in order
// until a hit or the last one, a dump reads and sends each entry, insert reads and writes back
// each entry moved up and then writes the new value, and delete each entry moved down; the
// list memory, with its registered read, sets this pace. A two-word queue lets new commands
// be taken during execution, and a result register lets execution go on while a result waits.
module positional_list_insert_delete_search #(
    parameter int DEPTH = plids_pkg::DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  plids_pkg::cmd_word_t cmd_word,
    output logic                 res_valid,
    input  logic                 res_stall,
    output plids_pkg::res_word_t res_word
);
    import plids_pkg::*;

    logic     q_full;
    logic     q_push;
    q_entry_t q_entry;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_head;

    plids_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    plids_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .head       (q_head)
    );

    plids_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (q_head),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

/* rtl/plids_front.sv */
// Command intake: accept words and decode them into queue entries.
module plids_front (
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  plids_pkg::cmd_word_t cmd_word,
    input  logic                 q_full,
    output logic                 q_push,
    output plids_pkg::q_entry_t  q_entry
);
    import plids_pkg::*;

    op_t op;

    always_comb
    begin
        case (cmd_word.cmd)
            CMD_CLEAR:  op = OP_CLEAR;
            CMD_APPEND: op = OP_APPEND;
            CMD_INSERT: op = OP_INSERT;
            CMD_DELETE: op = OP_DELETE;
            CMD_SEARCH: op = OP_SEARCH;
            CMD_DUMP:   op = OP_DUMP;
            default:    op = OP_BADCMD;
        endcase
    end

    assign cmd_stall        = q_full;
    assign q_push           = cmd_valid && !q_full;
    assign q_entry.op       = op;
    assign q_entry.position = cmd_word.position;
    assign q_entry.value    = cmd_word.operand_value;

endmodule

/* rtl/plids_queue.sv */
// Short queue of decoded commands between intake and execution.
module plids_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  plids_pkg::q_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output plids_pkg::q_entry_t head
);
    import plids_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int FILL_W = $clog2(QDEPTH + 1);

    q_entry_t            slot_reg [QDEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign full    = (fill_reg == FILL_W'(QDEPTH));
    assign q_valid = (fill_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];

endmodule

/* rtl/plids_back.sv */
// Command execution: list memory, count, shift/search/dump sequencer and result register.
module plids_back #(
    parameter int DEPTH = plids_pkg::DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  plids_pkg::q_entry_t  head,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output plids_pkg::res_word_t res_word
);
    import plids_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [VAL_W-1:0] mem [DEPTH];

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    status_t                 status_reg, status_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    res_valid_reg, res_valid_next;
    res_word_t               res_word_reg, res_word_next;

    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [VAL_W-1:0] wdata;
    logic                    re;
    logic [IDX_W-1:0]        raddr;
    logic                    emit;

    logic [POS_W-1:0]        cnt_ext;
    logic [POS_W-1:0]        idx_ext;
    logic                    is_full;
    logic                    is_empty;
    logic                    up_done;
    logic                    dn_done;
    logic                    last_ent;
    logic                    hit;
    logic                    can_load;

    assign cnt_ext  = POS_W'(count_reg);
    assign idx_ext  = POS_W'(idx_reg);
    assign is_full  = (count_reg >= CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign up_done  = (POS_W'(idx_reg - IDX_W'(1)) == pos_reg);
    assign dn_done  = ((idx_ext + POS_W'(2)) == cnt_ext);
    assign last_ent = ((idx_ext + POS_W'(1)) == cnt_ext);
    assign hit      = (rd_data_reg == val_reg);
    assign can_load = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (head.op)
                        OP_INSERT:
                        begin
                            if (head.position > cnt_ext || is_full
                                || head.position == cnt_ext)
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_UP_RD;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (is_empty || head.position >= cnt_ext
                                || (head.position + POS_W'(1)) == cnt_ext)
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_DN_RD;
                            end
                        end
                        OP_SEARCH:
                        begin
                            state_next = is_empty ? ST_RESP : ST_SRCH_RD;
                        end
                        OP_DUMP:
                        begin
                            state_next = is_empty ? ST_RESP : ST_DUMP_RD;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_UP_RD:    state_next = ST_UP_WR;
            ST_UP_WR:    state_next = up_done ? ST_PUT : ST_UP_RD;
            ST_PUT:      state_next = ST_RESP;
            ST_DN_RD:    state_next = ST_DN_WR;
            ST_DN_WR:    state_next = dn_done ? ST_RESP : ST_DN_RD;
            ST_SRCH_RD:  state_next = ST_SRCH_CMP;
            ST_SRCH_CMP: state_next = (hit || last_ent) ? ST_RESP : ST_SRCH_RD;
            ST_DUMP_RD:  state_next = ST_DUMP_OUT;
            ST_DUMP_OUT:
            begin
                if (can_load)
                begin
                    state_next = last_ent ? ST_IDLE : ST_DUMP_RD;
                end
            end
            ST_RESP:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        hit_idx_next  = hit_idx_reg;
        pop           = 1'b0;
        we            = 1'b0;
        waddr         = idx_reg;
        wdata         = rd_data_reg;
        re            = 1'b0;
        raddr         = idx_reg;
        emit          = 1'b0;
        res_word_next = res_word_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop          = 1'b1;
                    pos_next     = head.position;
                    val_next     = head.value;
                    status_next  = STAT_OK;
                    hit_idx_next = '0;
                    case (head.op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = IDX_W'(count_reg);
                                wdata      = head.value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (head.position > cnt_ext)
                            begin
                                status_next = STAT_BADPOS;
                            end
                            else if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (head.position == cnt_ext)
                            begin
                                we         = 1'b1;
                                waddr      = IDX_W'(head.position);
                                wdata      = head.value;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                idx_next = IDX_W'(count_reg);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (head.position >= cnt_ext)
                            begin
                                status_next = STAT_BADPOS;
                            end
                            else if ((head.position + POS_W'(1)) == cnt_ext)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                idx_next = IDX_W'(head.position);
                            end
                        end
                        OP_SEARCH:
                        begin
                            idx_next = '0;
                            if (is_empty)
                            begin
                                status_next = STAT_NOTFOUND;
                            end
                        end
                        OP_DUMP:
                        begin
                            idx_next = '0;
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_BADCMD;
                        end
                    endcase
                end
            end
            ST_UP_RD:
            begin
                re    = 1'b1;
                raddr = idx_reg - IDX_W'(1);
            end
            ST_UP_WR:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                wdata = rd_data_reg;
                if (!up_done)
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_PUT:
            begin
                we         = 1'b1;
                waddr      = IDX_W'(pos_reg);
                wdata      = val_reg;
                count_next = count_reg + CNT_W'(1);
            end
            ST_DN_RD:
            begin
                re    = 1'b1;
                raddr = idx_reg + IDX_W'(1);
            end
            ST_DN_WR:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                wdata = rd_data_reg;
                if (dn_done)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SRCH_RD, ST_DUMP_RD:
            begin
                re    = 1'b1;
                raddr = idx_reg;
            end
            ST_SRCH_CMP:
            begin
                if (hit)
                begin
                    status_next  = STAT_OK;
                    hit_idx_next = idx_reg;
                end
                else if (last_ent)
                begin
                    status_next  = STAT_NOTFOUND;
                    hit_idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DUMP_OUT:
            begin
                if (can_load)
                begin
                    emit                      = 1'b1;
                    res_word_next.status      = STAT_OK;
                    res_word_next.found_index = FIDX_W'(idx_reg);
                    res_word_next.entry_value = rd_data_reg;
                    res_word_next.entry_count = cnt_ext;
                    res_word_next.last        = last_ent;
                    if (!last_ent)
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_RESP:
            begin
                if (can_load)
                begin
                    emit                      = 1'b1;
                    res_word_next.status      = status_reg;
                    res_word_next.found_index = FIDX_W'(hit_idx_reg);
                    res_word_next.entry_value = '0;
                    res_word_next.entry_count = cnt_ext;
                    res_word_next.last        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && res_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        status_reg   <= status_next;
        hit_idx_reg  <= hit_idx_next;
        res_word_reg <= res_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("list count beyond depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_CMP || state_reg == ST_DUMP_OUT) |-> idx_ext < cnt_ext)
        else $error("scan index beyond list count");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && q_valid && head.op == OP_CLEAR) |=> count_reg == '0)
        else $error("clear did not empty the list");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE && q_valid))
        else $error("queue popped while busy");

endmodule

/* verif/tb.sv */
// Testbench for the positional list: random and directed command words checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plids_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 400;

    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    class list_scoreboard;
        logic signed [VAL_W-1:0] entries [DEPTH];
        int                      n_entries;
        res_word_t               due [$];
        int                      errors;
        int                      checked;

        function int pending();
            return due.size();
        endfunction

        function void note_command(cmd_word_t w);
            res_word_t r;
            status_t   st;
            int        hit;
            int        i;
            st  = STAT_OK;
            hit = 0;
            case (w.cmd)
                CMD_CLEAR:  n_entries = 0;
                CMD_APPEND:
                    if (n_entries >= DEPTH)
                        st = STAT_FULL;
                    else
                    begin
                        entries[n_entries] = w.operand_value;
                        n_entries++;
                    end
                CMD_INSERT:
                    if (w.position > n_entries)
                        st = STAT_BADPOS;
                    else if (n_entries >= DEPTH)
                        st = STAT_FULL;
                    else
                    begin
                        for (i = n_entries; i > w.position; i--)
                            entries[i] = entries[i-1];
                        entries[w.position] = w.operand_value;
                        n_entries++;
                    end
                CMD_DELETE:
                    if (n_entries == 0)
                        st = STAT_EMPTY;
                    else if (w.position >= n_entries)
                        st = STAT_BADPOS;
                    else
                    begin
                        for (i = w.position; i + 1 < n_entries; i++)
                            entries[i] = entries[i+1];
                        n_entries--;
                    end
                CMD_SEARCH:
                begin
                    st = STAT_NOTFOUND;
                    for (i = 0; i < n_entries; i++)
                        if (st == STAT_NOTFOUND && entries[i] == w.operand_value)
                        begin
                            st  = STAT_OK;
                            hit = i;
                        end
                end
                CMD_DUMP:
                    if (n_entries == 0)
                        st = STAT_EMPTY;
                    else
                    begin
                        for (i = 0; i < n_entries; i++)
                        begin
                            r.status      = STAT_OK;
                            r.found_index = i[FIDX_W-1:0];
                            r.entry_value = entries[i];
                            r.entry_count = n_entries[POS_W-1:0];
                            r.last        = (i + 1 == n_entries);
                            due.push_back(r);
                        end
                        return;
                    end
                default:    st = STAT_BADCMD;
            endcase
            r.status      = st;
            r.found_index = hit[FIDX_W-1:0];
            r.entry_value = '0;
            r.entry_count = n_entries[POS_W-1:0];
            r.last        = 1'b1;
            due.push_back(r);
        endfunction

        function void cmp_field(string name, logic [31:0] e, logic [31:0] g);
            if (g !== e)
            begin
                $error("%s: expected %0h, got %0h", name, e, g);
                errors++;
            end
        endfunction

        function void check_result(res_word_t got);
            res_word_t exp;
            if (due.size() == 0)
            begin
                $error("result word with nothing outstanding: %h", got);
                errors++;
                return;
            end
            exp = due.pop_front();
            checked++;
            cmp_field("status", 32'(exp.status), 32'(got.status));
            cmp_field("found_index", 32'(exp.found_index), 32'(got.found_index));
            cmp_field("entry_value", 32'(exp.entry_value), 32'(got.entry_value));
            cmp_field("entry_count", 32'(exp.entry_count), 32'(got.entry_count));
            cmp_field("last", 32'(exp.last), 32'(got.last));
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_word_t cmd_word;
    logic      res_valid;
    logic      res_stall;
    res_word_t res_word;

    list_scoreboard sb = new();
    int             words_sent;
    bit             tx_steady;
    bit             long_hold_done;

    positional_list_insert_delete_search #(.DEPTH(DEPTH)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_word  <= '0;
        res_stall <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return $urandom_range(0, 3) - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                            input logic signed [VAL_W-1:0] v);
        cmd_word_t w;
        int        gap;
        w.cmd           = c;
        w.position      = p;
        w.operand_value = v;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        sb.note_command(w);
        words_sent++;
    endtask

    // hold the sender until every outstanding result has been taken
    task automatic pause_sender();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic random_op();
        int                      r;
        int                      cnt;
        logic [POS_W-1:0]        p;
        logic signed [VAL_W-1:0] v;
        cnt = sb.n_entries;
        r   = $urandom_range(0, 99);
        p   = POS_W'($urandom);
        v   = rand_value();
        if (r < 25 || (cnt < 3 && r < 50))
            send_cmd(CMD_APPEND, p, v);
        else if (r < 45)
        begin
            p = POS_W'(($urandom_range(0, 5) == 0) ? $urandom_range(cnt + 1, 127)
                                                   : $urandom_range(0, cnt));
            send_cmd(CMD_INSERT, p, v);
        end
        else if (r < 65)
        begin
            p = POS_W'((cnt == 0 || $urandom_range(0, 5) == 0) ? $urandom_range(cnt, 127)
                                                               : $urandom_range(0, cnt - 1));
            send_cmd(CMD_DELETE, p, v);
        end
        else if (r < 85)
        begin
            if (cnt > 0 && $urandom_range(0, 9) < 7)
                v = sb.entries[$urandom_range(0, cnt - 1)];
            send_cmd(CMD_SEARCH, p, v);
        end
        else if (r < 92)
            send_cmd(CMD_DUMP, p, v);
        else if (r < 95)
            send_cmd(CMD_CLEAR, p, v);
        else
            send_cmd($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7, p, v);
    endtask

    task automatic fill_list();
        while (sb.n_entries < DEPTH)
            send_cmd(CMD_APPEND, POS_W'($urandom), rand_value());
        send_cmd(CMD_APPEND, 0, rand_value());
        send_cmd(CMD_INSERT, POS_W'($urandom_range(0, DEPTH)), rand_value());
        send_cmd(CMD_INSERT, POS_W'(DEPTH + 1), rand_value());
        send_cmd(CMD_SEARCH, 0, sb.entries[DEPTH-1]);
        send_cmd(CMD_DUMP, 0, 0);
        send_cmd(CMD_DELETE, POS_W'(DEPTH), 0);
        send_cmd(CMD_DELETE, POS_W'(DEPTH - 1), 0);
        send_cmd(CMD_INSERT, POS_W'(DEPTH - 1), rand_value());
        send_cmd(CMD_DELETE, 0, 0);
    endtask

    initial
    begin : stimulus
        int seg;
        bit filled;
        @(posedge rst_n);
        @(posedge clk);
        tx_steady = 1'b0;
        send_cmd(CMD_DUMP, 0, 0);
        send_cmd(CMD_DELETE, 0, 0);
        send_cmd(CMD_SEARCH, 0, 0);
        send_cmd(CMD_INSERT, 1, 32'sd9);
        send_cmd(CMD_INSERT, 0, 32'sh7fff_ffff);
        send_cmd(CMD_APPEND, 0, 32'sh8000_0000);
        send_cmd(CMD_APPEND, 0, -32'sd1);
        send_cmd(CMD_INSERT, 3, 32'sd0);
        send_cmd(CMD_INSERT, 1, 32'sd5);
        send_cmd(CMD_APPEND, 0, 32'sd5);
        send_cmd(CMD_SEARCH, 0, 32'sd5);
        send_cmd(CMD_SEARCH, 0, 32'sh8000_0000);
        send_cmd(CMD_SEARCH, 0, 32'sd12345);
        send_cmd(CMD_DELETE, 6, 0);
        send_cmd(CMD_DELETE, 127, 0);
        send_cmd(CMD_INSERT, 127, -32'sd1);
        send_cmd(CMD_DELETE, 0, 0);
        send_cmd(CMD_DELETE, 2, 0);
        send_cmd(CMD_DELETE, 2, 0);
        send_cmd(CMD_SPARE6, 127, -32'sd1);
        send_cmd(CMD_SPARE7, 0, 32'sh7fff_ffff);
        send_cmd(CMD_DUMP, 127, -32'sd1);
        send_cmd(CMD_CLEAR, 127, -32'sd1);
        send_cmd(CMD_DUMP, 0, 0);
        pause_sender();

        filled = 1'b0;
        seg    = 0;
        while (words_sent < 150)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            if (!filled && seg == 4)
            begin
                fill_list();
                filled = 1'b1;
            end
            else if (long_hold_done && $urandom_range(0, 5) == 0)
                pause_sender();
            else
                repeat ($urandom_range(8, 16)) random_op();
            seg++;
        end

        pause_sender();
        repeat (2 * DEPTH + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && sb.checked >= 30)
            begin
                long_hold_done = 1'b1;
                n = HOLD_LEN;
            end
            else
                n = pick_gap();
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 4)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_word);
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle = 0;
            else
                idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
